// ===== rtl/pfft_pkg.sv =====
// ----------------------------------------------------------------------------
// pfft_pkg
// Shared constants, types and state encoding for the page fault / TLB fill
// core.
// ----------------------------------------------------------------------------
`default_nettype none

package pfft_pkg;

	// Table geometry
	localparam int FRAME_COUNT = 32;
	localparam int SLOT_COUNT  = 4;
	localparam int PAGE_BYTES  = 128;

	localparam int ADDR_W      = 32;
	localparam int PID_W       = 8;
	localparam int PAGES_W     = 26;
	localparam int TIME_W      = 32;

	localparam int FRAME_IDX_W = $clog2(FRAME_COUNT);
	localparam int SLOT_IDX_W  = $clog2(SLOT_COUNT);
	localparam int LINK_W      = $clog2(SLOT_COUNT + 1);
	localparam int CNT_W       = $clog2(FRAME_COUNT + 1);
	localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
	localparam int VPN_W       = ADDR_W - PAGE_SHIFT;

	// Slot link value meaning "frame not in the TLB"
	localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(SLOT_COUNT);

	// One frame table entry as kept in the frame RAM
	typedef struct packed {
		logic [PID_W-1:0]  owner;
		logic [VPN_W-1:0]  page;
		logic [TIME_W-1:0] last_used;
	} frame_entry_t;

	localparam int ENTRY_W = $bits(frame_entry_t);

	// Result of one pass over the frame table
	typedef struct packed {
		logic                   hit;
		logic [FRAME_IDX_W-1:0] hit_idx;
		logic                   free;
		logic [FRAME_IDX_W-1:0] free_idx;
		logic [FRAME_IDX_W-1:0] best_idx;
		logic [PID_W-1:0]       best_owner;
		logic [VPN_W-1:0]       best_page;
	} scan_res_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESOLVE,
		ST_FILL
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/pfft_ram.sv =====
// ----------------------------------------------------------------------------
// pfft_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic                     we,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Registered read; a write cycle returns the old contents
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

// ===== rtl/pfft_scan.sv =====
// ----------------------------------------------------------------------------
// pfft_scan
// Compare unit stepped once per frame entry: tracks the first matching
// frame, the first invalid frame and the least recently used frame.
// ----------------------------------------------------------------------------
`default_nettype none

module pfft_scan (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            clear,
	input  wire logic                            eval,
	input  wire logic [pfft_pkg::FRAME_IDX_W-1:0] idx,
	input  wire logic                            entry_valid,
	input  wire pfft_pkg::frame_entry_t          entry,
	input  wire logic [pfft_pkg::PID_W-1:0]      pid,
	input  wire logic [pfft_pkg::VPN_W-1:0]      vpn,
	output pfft_pkg::scan_res_t                  res
);

	logic                             hit_q;
	logic                             free_q;
	logic [pfft_pkg::FRAME_IDX_W-1:0] hit_idx_q;
	logic [pfft_pkg::FRAME_IDX_W-1:0] free_idx_q;
	logic [pfft_pkg::FRAME_IDX_W-1:0] best_idx_q;
	logic [pfft_pkg::TIME_W-1:0]      best_time_q;
	logic [pfft_pkg::PID_W-1:0]       best_owner_q;
	logic [pfft_pkg::VPN_W-1:0]       best_page_q;

	logic is_match;
	logic take_hit;
	logic take_free;
	logic take_best;

	// Compare of the current entry
	assign is_match  = entry_valid && (entry.owner == pid) && (entry.page == vpn);
	assign take_hit  = eval && !hit_q && is_match;
	assign take_free = eval && !free_q && !entry_valid;
	assign take_best = eval && ((idx == '0) || (entry.last_used < best_time_q));

	// Found flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (clear) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (take_hit) begin
				hit_q <= 1'b1;
			end
			if (take_free) begin
				free_q <= 1'b1;
			end
		end
	end

	// Tracked indices and LRU candidate
	always_ff @(posedge clk) begin
		if (take_hit) begin
			hit_idx_q <= idx;
		end
		if (take_free) begin
			free_idx_q <= idx;
		end
		if (take_best) begin
			best_idx_q   <= idx;
			best_time_q  <= entry.last_used;
			best_owner_q <= entry.owner;
			best_page_q  <= entry.page;
		end
	end

	always_comb begin
		res.hit        = hit_q;
		res.hit_idx    = hit_idx_q;
		res.free       = free_q;
		res.free_idx   = free_idx_q;
		res.best_idx   = best_idx_q;
		res.best_owner = best_owner_q;
		res.best_page  = best_page_q;
	end

endmodule

`default_nettype wire

// ===== rtl/page_fault_frame_and_tlb_fill_core.sv =====
// ----------------------------------------------------------------------------
// page_fault_frame_and_tlb_fill_core
// TLB miss handler: inverted page table lookup, LRU frame replacement and
// FIFO TLB slot fill.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) takes one TLB miss transaction:
//    fault address, process id, process page count and current time.
//  - Output channel (out_valid/out_ready) returns one result transaction
//    per miss: error flag, hit flag, frame, TLB slot and evicted page.
//  - After acceptance the result passes through the read latency of the
//    single-port frame RAM, a scan of every frame entry through that RAM
//    and the compare unit, then a resolve step and a fill step before it is
//    valid. An address error skips the fill.
//  - in_ready is high only while the sequencer is idle, from the cycle after
//    the result is loaded; no new miss is taken until the previous one has
//    been loaded. A new transaction may be accepted while the previous result
//    still waits in the output register.
//  - When the receiver stalls, the sequencer holds in its last step until
//    the output register is free; nothing is lost or repeated.
//  - Reset clears all frame and slot valid bits, slot links and the FIFO
//    pointer; frame RAM contents are read only behind their valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module page_fault_frame_and_tlb_fill_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [pfft_pkg::ADDR_W-1:0]       fault_address,
	input  wire logic [pfft_pkg::PID_W-1:0]        process_id,
	input  wire logic [pfft_pkg::PAGES_W-1:0]      process_pages,
	input  wire logic [pfft_pkg::TIME_W-1:0]       current_time,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   address_error,
	output logic                                   found_resident,
	output logic [pfft_pkg::FRAME_IDX_W-1:0]       frame,
	output logic [pfft_pkg::SLOT_IDX_W-1:0]        tlb_slot,
	output logic                                   evicted_valid,
	output logic [pfft_pkg::PID_W-1:0]             evicted_owner,
	output logic [pfft_pkg::VPN_W-1:0]             evicted_page
);

	pfft_pkg::state_t state_q, state_d;

	// Captured transaction
	logic [pfft_pkg::VPN_W-1:0]   vpn_q;
	logic [pfft_pkg::PID_W-1:0]   pid_q;
	logic [pfft_pkg::PAGES_W-1:0] pages_q;
	logic [pfft_pkg::TIME_W-1:0]  now_q;

	// Scan counter and table state
	logic [pfft_pkg::CNT_W-1:0]       cnt_q;
	logic [pfft_pkg::FRAME_COUNT-1:0] frame_valid_q;
	logic [pfft_pkg::LINK_W-1:0]      link_q [pfft_pkg::FRAME_COUNT];
	logic [pfft_pkg::SLOT_COUNT-1:0]  slot_valid_q;
	logic [pfft_pkg::FRAME_IDX_W-1:0] slot_frame_q [pfft_pkg::SLOT_COUNT];
	logic [pfft_pkg::SLOT_IDX_W-1:0]  fifo_q;

	// Resolved miss
	logic [pfft_pkg::FRAME_IDX_W-1:0] frm_q;
	logic                             hit_q;
	logic                             ev_q;
	logic [pfft_pkg::PID_W-1:0]       ev_owner_q;
	logic [pfft_pkg::VPN_W-1:0]       ev_page_q;

	// Output register
	logic                             out_valid_q;
	logic                             out_err_q;
	logic                             out_hit_q;
	logic [pfft_pkg::FRAME_IDX_W-1:0] out_frame_q;
	logic [pfft_pkg::SLOT_IDX_W-1:0]  out_slot_q;
	logic                             out_ev_q;
	logic [pfft_pkg::PID_W-1:0]       out_ev_owner_q;
	logic [pfft_pkg::VPN_W-1:0]       out_ev_page_q;

	logic                             accept;
	logic                             out_free;
	logic                             scan_eval;
	logic [pfft_pkg::FRAME_IDX_W-1:0] scan_idx;
	logic                             scan_done;
	pfft_pkg::scan_res_t              scan_res;
	pfft_pkg::frame_entry_t           ram_wdata;
	pfft_pkg::frame_entry_t           ram_rdata;
	logic [pfft_pkg::ENTRY_W-1:0]     ram_rdata_raw;
	logic [pfft_pkg::FRAME_IDX_W-1:0] ram_addr;
	logic                             ram_we;

	logic                             miss_err;
	logic [pfft_pkg::FRAME_IDX_W-1:0] frm_sel;
	logic                             evict_sel;
	logic [pfft_pkg::LINK_W-1:0]      victim_link;
	logic                             resolve_go;
	logic                             resolve_err;
	logic                             fill_go;
	logic                             free_slot_got;
	logic [pfft_pkg::SLOT_IDX_W-1:0]  free_slot;
	logic [pfft_pkg::SLOT_IDX_W-1:0]  fill_slot;
	logic                             old_slot_valid;
	logic [pfft_pkg::FRAME_IDX_W-1:0] old_slot_frame;
	logic [pfft_pkg::SLOT_IDX_W-1:0]  fifo_next;

	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign scan_idx  = pfft_pkg::FRAME_IDX_W'(cnt_q - pfft_pkg::CNT_W'(1));
	assign scan_done = (cnt_q == pfft_pkg::CNT_W'(pfft_pkg::FRAME_COUNT));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfft_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = pfft_pkg::ST_SCAN;
				end
			end
			pfft_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = pfft_pkg::ST_RESOLVE;
				end
			end
			pfft_pkg::ST_RESOLVE: begin
				if (!miss_err) begin
					state_d = pfft_pkg::ST_FILL;
				end else if (out_free) begin
					state_d = pfft_pkg::ST_IDLE;
				end
			end
			pfft_pkg::ST_FILL: begin
				if (out_free) begin
					state_d = pfft_pkg::ST_IDLE;
				end
			end
			default: state_d = pfft_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready    = 1'b0;
		scan_eval   = 1'b0;
		ram_addr    = pfft_pkg::FRAME_IDX_W'(cnt_q);
		ram_we      = 1'b0;
		resolve_go  = 1'b0;
		resolve_err = 1'b0;
		fill_go     = 1'b0;
		unique case (state_q)
			pfft_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			pfft_pkg::ST_SCAN: begin
				scan_eval = (cnt_q != '0);
			end
			pfft_pkg::ST_RESOLVE: begin
				ram_addr    = frm_sel;
				ram_we      = !miss_err;
				resolve_go  = !miss_err;
				resolve_err = miss_err && out_free;
			end
			pfft_pkg::ST_FILL: begin
				fill_go = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfft_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			vpn_q   <= fault_address[pfft_pkg::ADDR_W-1:pfft_pkg::PAGE_SHIFT];
			pid_q   <= process_id;
			pages_q <= process_pages;
			now_q   <= current_time;
		end
	end

	// Scan counter: issue read for entry cnt, evaluate entry cnt-1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= '0;
		end else if (state_q == pfft_pkg::ST_SCAN && !scan_done) begin
			cnt_q <= cnt_q + pfft_pkg::CNT_W'(1);
		end
	end

	// Frame RAM: owner, page and last-used stamp
	assign ram_wdata.owner     = pid_q;
	assign ram_wdata.page      = vpn_q;
	assign ram_wdata.last_used = now_q;
	assign ram_rdata           = pfft_pkg::frame_entry_t'(ram_rdata_raw);

	pfft_ram #(
		.WIDTH(pfft_pkg::ENTRY_W),
		.DEPTH(pfft_pkg::FRAME_COUNT)
	) u_frame_ram (
		.clk  (clk),
		.addr (ram_addr),
		.we   (ram_we),
		.wdata(ram_wdata),
		.rdata(ram_rdata_raw)
	);

	pfft_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (accept),
		.eval       (scan_eval),
		.idx        (scan_idx),
		.entry_valid(frame_valid_q[scan_idx]),
		.entry      (ram_rdata),
		.pid        (pid_q),
		.vpn        (vpn_q),
		.res        (scan_res)
	);

	// Resolve: hit, address error, free frame or LRU victim
	assign miss_err    = !scan_res.hit &&
		({1'b0, vpn_q} >= pfft_pkg::PAGES_W'(pages_q));
	assign frm_sel     = scan_res.hit ? scan_res.hit_idx :
		(scan_res.free ? scan_res.free_idx : scan_res.best_idx);
	assign evict_sel   = !scan_res.hit && !scan_res.free;
	assign victim_link = link_q[frm_sel];

	always_ff @(posedge clk) begin
		if (resolve_go) begin
			frm_q      <= frm_sel;
			hit_q      <= scan_res.hit;
			ev_q       <= evict_sel;
			ev_owner_q <= evict_sel ? scan_res.best_owner : '0;
			ev_page_q  <= evict_sel ? scan_res.best_page : '0;
		end
	end

	// Fill: first free slot, else FIFO pointer
	always_comb begin
		free_slot_got = 1'b0;
		free_slot     = '0;
		for (int i = pfft_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
			if (!slot_valid_q[i]) begin
				free_slot_got = 1'b1;
				free_slot     = pfft_pkg::SLOT_IDX_W'(i);
			end
		end
	end

	assign fill_slot      = free_slot_got ? free_slot : fifo_q;
	assign old_slot_valid = slot_valid_q[fill_slot];
	assign old_slot_frame = slot_frame_q[fill_slot];
	assign fifo_next      = (fill_slot == pfft_pkg::SLOT_IDX_W'(pfft_pkg::SLOT_COUNT - 1)) ?
		'0 : fill_slot + pfft_pkg::SLOT_IDX_W'(1);

	// Frame valid bits, slot links, slot valid bits and FIFO pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= '0;
			slot_valid_q  <= '0;
			fifo_q        <= '0;
			for (int j = 0; j < pfft_pkg::FRAME_COUNT; j++) begin
				link_q[j] <= pfft_pkg::NO_SLOT;
			end
		end else if (resolve_go) begin
			frame_valid_q[frm_sel] <= 1'b1;
			if (!scan_res.hit) begin
				link_q[frm_sel] <= pfft_pkg::NO_SLOT;
			end
			if (evict_sel && (victim_link < pfft_pkg::NO_SLOT)) begin
				slot_valid_q[victim_link[pfft_pkg::SLOT_IDX_W-1:0]] <= 1'b0;
			end
		end else if (fill_go) begin
			slot_valid_q[fill_slot] <= 1'b1;
			fifo_q                  <= fifo_next;
			for (int j = 0; j < pfft_pkg::FRAME_COUNT; j++) begin
				if (pfft_pkg::FRAME_IDX_W'(j) == frm_q) begin
					link_q[j] <= pfft_pkg::LINK_W'(fill_slot);
				end else if (old_slot_valid &&
					(old_slot_frame == pfft_pkg::FRAME_IDX_W'(j))) begin
					link_q[j] <= pfft_pkg::NO_SLOT;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fill_go) begin
			slot_frame_q[fill_slot] <= frm_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resolve_err || fill_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resolve_err) begin
			out_err_q      <= 1'b1;
			out_hit_q      <= 1'b0;
			out_frame_q    <= '0;
			out_slot_q     <= '0;
			out_ev_q       <= 1'b0;
			out_ev_owner_q <= '0;
			out_ev_page_q  <= '0;
		end else if (fill_go) begin
			out_err_q      <= 1'b0;
			out_hit_q      <= hit_q;
			out_frame_q    <= frm_q;
			out_slot_q     <= fill_slot;
			out_ev_q       <= ev_q;
			out_ev_owner_q <= ev_owner_q;
			out_ev_page_q  <= ev_page_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign address_error  = out_err_q;
	assign found_resident = out_hit_q;
	assign frame          = out_frame_q;
	assign tlb_slot       = out_slot_q;
	assign evicted_valid  = out_ev_q;
	assign evicted_owner  = out_ev_owner_q;
	assign evicted_page   = out_ev_page_q;

	// Checks
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_err_q) |-> (!out_hit_q && !out_ev_q && out_frame_q == '0))
		else $error("address error result carries frame data");

	a_evict_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ev_q) |-> !out_hit_q)
		else $error("eviction reported on a resident hit");

	a_frame_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_err_q) |-> frame_valid_q[out_frame_q])
		else $error("reported frame is not valid");

	a_slot_filled: assert property (@(posedge clk) disable iff (!arst_n)
		fill_go |=> (slot_valid_q[out_slot_q] && slot_frame_q[out_slot_q] == out_frame_q))
		else $error("filled slot not recorded");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pfft_pkg::ST_SCAN) |-> (cnt_q <= pfft_pkg::CNT_W'(pfft_pkg::FRAME_COUNT)))
		else $error("scan counter out of range");

endmodule

`default_nettype wire
